// ===== rtl/core/strided_nd_address_generator_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef STRIDED_ND_ADDRESS_GENERATOR_UNIT_MACROS_SVH
`define STRIDED_ND_ADDRESS_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SNDAG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SNDAG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sndag_pkg.sv =====
`default_nettype none
package sndag_pkg;

	localparam int DIM_W          = 13;
	localparam int STRIDE_W       = 32;
	localparam int CFG_DATA_W     = 32;
	localparam int OFFSET_W       = 46;
	localparam int FLAT_W         = 48;
	localparam int MAX_RANK_DEF   = 4;
	localparam int INDEX_BITS_DEF = 12;
	// Registers from the input edge to the result register, inclusive.
	localparam int PIPE_DEPTH     = 4;

	typedef struct packed {
		logic [FLAT_W-1:0] flat_index;
		logic              last_element;
		logic              empty_tensor;
	} elem_info_t;

endpackage
`default_nettype wire

// ===== rtl/core/sndag_if.sv =====
`default_nettype none
interface sndag_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface sndag_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [sndag_pkg::OFFSET_W-1:0] byte_offset;
	logic [sndag_pkg::FLAT_W-1:0]   flat_index;
	logic                           last_element;
	logic                           empty_tensor;

	modport source (output valid, output byte_offset, output flat_index,
		output last_element, output empty_tensor, input ready);
	modport sink (input valid, input byte_offset, input flat_index,
		input last_element, input empty_tensor, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sndag_cfg_regs.sv =====
`default_nettype none
module sndag_cfg_regs #(
	parameter int MAX_RANK  = sndag_pkg::MAX_RANK_DEF,
	parameter int CFG_IDX_W = $clog2(2 * MAX_RANK)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [CFG_IDX_W-1:0]             cfg_index,
	input  wire logic [sndag_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic      [sndag_pkg::DIM_W-1:0]      dim_extent [MAX_RANK],
	output logic      [sndag_pkg::STRIDE_W-1:0]   stride_bytes [MAX_RANK]
);

	logic [sndag_pkg::DIM_W-1:0]    dim_extent_q [MAX_RANK];
	logic [sndag_pkg::STRIDE_W-1:0] stride_q     [MAX_RANK];

	// Indexes at or beyond twice the rank match no register and are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_RANK; d++) begin
				dim_extent_q[d] <= sndag_pkg::DIM_W'(1);
				stride_q[d]     <= (d == MAX_RANK - 1) ? sndag_pkg::STRIDE_W'(1)
				                                       : sndag_pkg::STRIDE_W'(0);
			end
		end else if (cfg_we) begin
			for (int d = 0; d < MAX_RANK; d++) begin
				if (cfg_index == CFG_IDX_W'(d))
					dim_extent_q[d] <= cfg_wdata[sndag_pkg::DIM_W-1:0];
				if (cfg_index == CFG_IDX_W'(MAX_RANK + d))
					stride_q[d] <= cfg_wdata[sndag_pkg::STRIDE_W-1:0];
			end
		end
	end

	assign dim_extent   = dim_extent_q;
	assign stride_bytes = stride_q;

endmodule
`default_nettype wire

// ===== rtl/core/sndag_odometer.sv =====
`default_nettype none
module sndag_odometer #(
	parameter int MAX_RANK   = sndag_pkg::MAX_RANK_DEF,
	parameter int INDEX_BITS = sndag_pkg::INDEX_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic                        restart,
	input  wire logic [sndag_pkg::DIM_W-1:0] dim_extent [MAX_RANK],
	output logic      [INDEX_BITS-1:0]       elem_idx [MAX_RANK],
	output sndag_pkg::elem_info_t            elem_info
);

	localparam int EXT_W = INDEX_BITS + 1;
	localparam int CMP_W = (sndag_pkg::DIM_W > EXT_W) ? sndag_pkg::DIM_W : EXT_W;
	localparam logic [CMP_W-1:0] EXT_CAP = CMP_W'(1) << INDEX_BITS;

	logic [INDEX_BITS-1:0]        idx_q    [MAX_RANK];
	logic [sndag_pkg::FLAT_W-1:0] flat_q;
	logic [INDEX_BITS-1:0]        cur_idx  [MAX_RANK];
	logic [INDEX_BITS-1:0]        nxt_idx  [MAX_RANK];
	logic [EXT_W-1:0]             extent   [MAX_RANK];
	logic [sndag_pkg::FLAT_W-1:0] cur_flat;
	logic [sndag_pkg::FLAT_W-1:0] nxt_flat;
	logic                         empty;
	logic                         last;

	// Extents above the counter range saturate at two to the index width.
	always_comb begin
		logic [CMP_W-1:0] raw;
		for (int d = 0; d < MAX_RANK; d++) begin
			raw       = CMP_W'(dim_extent[d]);
			extent[d] = (raw > EXT_CAP) ? EXT_W'(EXT_CAP) : EXT_W'(raw);
		end
	end

	always_comb begin
		empty = 1'b0;
		last  = 1'b1;
		for (int d = 0; d < MAX_RANK; d++) begin
			cur_idx[d] = restart ? '0 : idx_q[d];
			if (extent[d] == '0)
				empty = 1'b1;
			if (EXT_W'(cur_idx[d]) != extent[d] - EXT_W'(1))
				last = 1'b0;
		end
		cur_flat = restart ? '0 : flat_q;
	end

	// Ripple the increment from the innermost index outward.
	always_comb begin
		logic             carry;
		logic [EXT_W-1:0] nx;
		carry = 1'b1;
		for (int d = MAX_RANK - 1; d >= 0; d--) begin
			nx = EXT_W'(cur_idx[d]) + EXT_W'(1);
			if (!carry)
				nxt_idx[d] = cur_idx[d];
			else if (nx < extent[d]) begin
				nxt_idx[d] = nx[INDEX_BITS-1:0];
				carry      = 1'b0;
			end else
				nxt_idx[d] = '0;
		end
		nxt_flat = cur_flat + sndag_pkg::FLAT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_RANK; d++)
				idx_q[d] <= '0;
			flat_q <= '0;
		end else if (advance) begin
			priority if (empty) begin
				idx_q  <= cur_idx;
				flat_q <= cur_flat;
			end else if (last) begin
				for (int d = 0; d < MAX_RANK; d++)
					idx_q[d] <= '0;
				flat_q <= '0;
			end else begin
				idx_q  <= nxt_idx;
				flat_q <= nxt_flat;
			end
		end
	end

	// An empty tensor reports zero indices so that the offset sums to zero.
	always_comb begin
		for (int d = 0; d < MAX_RANK; d++)
			elem_idx[d] = empty ? '0 : cur_idx[d];
		elem_info.flat_index   = empty ? '0 : cur_flat;
		elem_info.last_element = !empty && last;
		elem_info.empty_tensor = empty;
	end

endmodule
`default_nettype wire

// ===== rtl/core/sndag_offset_pipe.sv =====
`default_nettype none
module sndag_offset_pipe #(
	parameter int MAX_RANK   = sndag_pkg::MAX_RANK_DEF,
	parameter int INDEX_BITS = sndag_pkg::INDEX_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [INDEX_BITS-1:0]          elem_idx [MAX_RANK],
	input  wire sndag_pkg::elem_info_t          elem_info,
	input  wire logic [sndag_pkg::STRIDE_W-1:0] stride_bytes [MAX_RANK],
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [sndag_pkg::OFFSET_W-1:0] out_offset,
	output sndag_pkg::elem_info_t               out_info
);

	localparam int PROD_W = INDEX_BITS + sndag_pkg::STRIDE_W;
	localparam int NPAIR  = (MAX_RANK + 1) / 2;

	logic                           v_s1, v_s2, v_s3, v_q;
	logic                           rdy_s2, rdy_s3, rdy_q;
	logic [INDEX_BITS-1:0]          idx_s1  [MAX_RANK];
	logic [sndag_pkg::OFFSET_W-1:0] prod_s2 [2*NPAIR];
	logic [sndag_pkg::OFFSET_W-1:0] prod_d  [2*NPAIR];
	logic [sndag_pkg::OFFSET_W-1:0] psum_s3 [NPAIR];
	logic [sndag_pkg::OFFSET_W-1:0] offset_d;
	logic [sndag_pkg::OFFSET_W-1:0] offset_q;
	sndag_pkg::elem_info_t          info_s1, info_s2, info_s3, info_q;

	// Each stage takes a new item when it is empty or its item moves on.
	assign rdy_q    = !v_q || out_ready;
	assign rdy_s3   = !v_s3 || rdy_q;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign in_ready = !v_s1 || rdy_s2;

	always_comb begin
		logic [PROD_W-1:0] p;
		for (int k = 0; k < 2 * NPAIR; k++)
			prod_d[k] = '0;
		for (int d = 0; d < MAX_RANK; d++) begin
			p         = PROD_W'(idx_s1[d]) * PROD_W'(stride_bytes[d]);
			prod_d[d] = sndag_pkg::OFFSET_W'(p);
		end
	end

	always_comb begin
		offset_d = '0;
		for (int k = 0; k < NPAIR; k++)
			offset_d = offset_d + psum_s3[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
			if (rdy_s3)
				v_s3 <= v_s2;
			if (rdy_q)
				v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			idx_s1  <= elem_idx;
			info_s1 <= elem_info;
		end
		if (rdy_s2 && v_s1) begin
			prod_s2 <= prod_d;
			info_s2 <= info_s1;
		end
		if (rdy_s3 && v_s2) begin
			for (int k = 0; k < NPAIR; k++)
				psum_s3[k] <= prod_s2[2*k] + prod_s2[2*k+1];
			info_s3 <= info_s2;
		end
		if (rdy_q && v_s3) begin
			offset_q <= offset_d;
			info_q   <= info_s3;
		end
	end

	assign out_valid  = v_q;
	assign out_offset = offset_q;
	assign out_info   = info_q;

endmodule
`default_nettype wire

// ===== rtl/core/strided_nd_address_generator_unit.sv =====
// Channel  Role    Payload
// req      sink    restart
// rsp      source  byte_offset, flat_index, last_element, empty_tensor
// cfg      write   cfg_we, cfg_index, cfg_wdata (no read-back)
//
// One item is accepted per cycle unless a stalled result backs up the pipeline.
// Four registers (input, products, pair sums, total offset) carry each item to its result.
// The walk state advances in the cycle an item is accepted; offsets follow in the pipeline.
// Reset (arst_n low) clears the walk, the pipeline valids and sets the register defaults.
// A stalled result holds in the output register while the stages behind it keep filling.
`default_nettype none
module strided_nd_address_generator_unit #(
	parameter int MAX_RANK   = sndag_pkg::MAX_RANK_DEF,
	parameter int INDEX_BITS = sndag_pkg::INDEX_BITS_DEF,
	parameter int CFG_IDX_W  = $clog2(2 * MAX_RANK)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [CFG_IDX_W-1:0]             cfg_index,
	input  wire logic [sndag_pkg::CFG_DATA_W-1:0] cfg_wdata,
	sndag_req_if.sink                             req,
	sndag_rsp_if.source                           rsp
);

	logic [sndag_pkg::DIM_W-1:0]    dim_extent   [MAX_RANK];
	logic [sndag_pkg::STRIDE_W-1:0] stride_bytes [MAX_RANK];
	logic [INDEX_BITS-1:0]          elem_idx     [MAX_RANK];
	sndag_pkg::elem_info_t          elem_info;
	sndag_pkg::elem_info_t          out_info;
	logic                           req_ready;
	logic                           req_fire;

	assign req_fire  = req.valid && req_ready;
	assign req.ready = req_ready;

	sndag_cfg_regs #(
		.MAX_RANK (MAX_RANK),
		.CFG_IDX_W(CFG_IDX_W)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.dim_extent  (dim_extent),
		.stride_bytes(stride_bytes)
	);

	sndag_odometer #(
		.MAX_RANK  (MAX_RANK),
		.INDEX_BITS(INDEX_BITS)
	) u_odo (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (req_fire),
		.restart   (req.restart),
		.dim_extent(dim_extent),
		.elem_idx  (elem_idx),
		.elem_info (elem_info)
	);

	sndag_offset_pipe #(
		.MAX_RANK  (MAX_RANK),
		.INDEX_BITS(INDEX_BITS)
	) u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_ready    (req_ready),
		.elem_idx    (elem_idx),
		.elem_info   (elem_info),
		.stride_bytes(stride_bytes),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_offset  (rsp.byte_offset),
		.out_info    (out_info)
	);

	assign rsp.flat_index   = out_info.flat_index;
	assign rsp.last_element = out_info.last_element;
	assign rsp.empty_tensor = out_info.empty_tensor;

endmodule
`default_nettype wire

// ===== rtl/core/sndag_checker.sv =====
`default_nettype none
`include "strided_nd_address_generator_unit_macros.svh"
module sndag_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           req_valid,
	input wire logic                           req_ready,
	input wire logic                           rsp_valid,
	input wire logic                           rsp_ready,
	input wire logic [sndag_pkg::OFFSET_W-1:0] byte_offset,
	input wire logic [sndag_pkg::FLAT_W-1:0]   flat_index,
	input wire logic                           last_element,
	input wire logic                           empty_tensor
);

	localparam int CNT_W = $clog2(sndag_pkg::PIPE_DEPTH + 2);

	logic [CNT_W-1:0] pending_q;
	logic             req_fire;
	logic             rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// Items accepted whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (req_fire && !rsp_fire)
			pending_q <= pending_q + CNT_W'(1);
		else if (rsp_fire && !req_fire && pending_q != '0)
			pending_q <= pending_q - CNT_W'(1);
	end

	`SNDAG_ASSERT_IMP(a_empty_zero, clk, arst_n, rsp_valid && empty_tensor,
		byte_offset == '0 && flat_index == '0 && !last_element,
		"empty tensor result carries nonzero fields")
	`SNDAG_ASSERT_IMP(a_no_spurious, clk, arst_n, rsp_valid, pending_q != '0,
		"result shown with no item outstanding")
	`SNDAG_ASSERT_IMP(a_depth_bound, clk, arst_n, 1'b1,
		pending_q <= CNT_W'(sndag_pkg::PIPE_DEPTH),
		"more items in flight than pipeline registers")
	`SNDAG_ASSERT_NXT(a_stall_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(byte_offset) && $stable(flat_index)
			&& $stable(last_element) && $stable(empty_tensor),
		"stalled result changed or dropped")

endmodule

bind strided_nd_address_generator_unit sndag_checker u_sndag_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.byte_offset (rsp.byte_offset),
	.flat_index  (rsp.flat_index),
	.last_element(rsp.last_element),
	.empty_tensor(rsp.empty_tensor)
);
`default_nettype wire
